### hdl/kfu_pkg.sv
// shared types and codes for the keyed fifo with update and range query
`timescale 1ns / 1ps

package kfu_pkg;

   // operation codes of an input word
   localparam logic [1:0] FUNC_ENQ = 2'd0;
   localparam logic [1:0] FUNC_DEQ = 2'd1;
   localparam logic [1:0] FUNC_RNG = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic signed [31:0] range_start;
      logic signed [31:0] range_end;
   } req_type;

   typedef struct packed {
      logic               success;
      logic signed [31:0] out_key;
      logic signed [31:0] out_value;
      logic               last;
   } rsp_type;

   localparam rsp_type FAIL_RSP = '{success: 1'b0, out_key: '0, out_value: '0, last: 1'b1};

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the accepted word and arm the scan
      logic scan;     // step the key scan
      logic finish;   // commit the operation and write the closing result
   } kfu_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic enq_hit;
      logic scan_end;
      logic out_free;
   } kfu_sts_type;

endpackage

### hdl/kfu_ram.sv
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module kfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/kfu_ctrl.sv
// operation sequencer: accept, key scan, commit
`timescale 1ns / 1ps

module kfu_ctrl import kfu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  kfu_sts_type sts,
   output kfu_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // an empty queue has nothing to scan
               if ((req_func == FUNC_ENQ || req_func == FUNC_RNG) && !sts.empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.enq_hit || sts.scan_end) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/kfu_dp.sv
// queue datapath: key and value rams, pointers, scan pipeline, result registers
`timescale 1ns / 1ps

module kfu_dp import kfu_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  kfu_cmd_type cmd,
   output kfu_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   req_type          req_ff, req_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_slot_ff, cmp_slot_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_slot_ff, hit_slot_in;
   logic [31:0]      hold_key_ff, hold_key_in;
   logic [31:0]      hold_val_ff, hold_val_in;
   logic             hold_vld_ff, hold_vld_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic [31:0]      key_rd, val_rd;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             key_we, val_we, out_load;
   logic             empty, full, key_eq, in_rng, is_enq, is_rng;
   logic             out_free, rng_hit, stall;

   kfu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (req_ff.key),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   kfu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (req_ff.value),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);
   assign is_enq   = (req_ff.func == FUNC_ENQ);
   assign is_rng   = (req_ff.func == FUNC_RNG);
   assign key_eq   = cmp_vld_ff && (key_rd == req_ff.key);
   assign in_rng   = cmp_vld_ff && ($signed(key_rd) >= req_ff.range_start)
                     && ($signed(key_rd) <= req_ff.range_end);
   assign out_free = !rsp_vld_ff || rsp_ready;
   assign rng_hit  = cmd.scan && is_rng && in_rng;
   // a second match with the held one still unsent and the output busy
   assign stall    = rng_hit && hold_vld_ff && !out_free;

   // while stalled, reread the slot under compare so its data stays put;
   // outside a scan the head slot is read continuously for dequeue
   assign rd_addr = cmd.scan ? (stall ? cmp_slot_ff : scan_slot_ff) : head_ff;

   assign sts.empty    = empty;
   assign sts.enq_hit  = is_enq && key_eq;
   assign sts.scan_end = (left_ff == '0) && !cmp_vld_ff;
   assign sts.out_free = out_free;

   always_comb begin
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_slot_in = scan_slot_ff;
      left_in      = left_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_slot_in  = cmp_slot_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hold_key_in  = hold_key_ff;
      hold_val_in  = hold_val_ff;
      hold_vld_in  = hold_vld_ff;
      rsp_in       = rsp_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;
      key_we       = 1'b0;
      val_we       = 1'b0;
      wr_addr      = tail_ff;
      out_load     = 1'b0;

      if (cmd.load) begin
         req_in       = req_data;
         scan_slot_in = head_ff;
         left_in      = count_ff;
         cmp_vld_in   = 1'b0;
         hit_in       = 1'b0;
         hold_vld_in  = 1'b0;
      end

      if (cmd.scan && !stall) begin
         if (left_ff != '0) begin
            cmp_vld_in   = 1'b1;
            cmp_slot_in  = scan_slot_ff;
            scan_slot_in = slot_after(scan_slot_ff);
            left_in      = left_ff - 1'b1;
         end else begin
            cmp_vld_in   = 1'b0;
         end
         if (is_enq && key_eq) begin
            hit_in      = 1'b1;
            hit_slot_in = cmp_slot_ff;
         end
         // keep one match back so the final one can carry last
         if (rng_hit) begin
            if (hold_vld_ff) begin
               rsp_in     = '{success: 1'b1, out_key: $signed(hold_key_ff),
                              out_value: $signed(hold_val_ff), last: 1'b0};
               rsp_vld_in = 1'b1;
               out_load   = 1'b1;
            end
            hold_key_in = key_rd;
            hold_val_in = val_rd;
            hold_vld_in = 1'b1;
         end
      end

      if (cmd.finish) begin
         out_load   = 1'b1;
         rsp_vld_in = 1'b1;
         rsp_in     = FAIL_RSP;
         unique case (req_ff.func)
            FUNC_ENQ: begin
               if (hit_ff) begin
                  val_we  = 1'b1;
                  wr_addr = hit_slot_ff;
                  rsp_in  = '{success: 1'b1, out_key: req_ff.key,
                              out_value: req_ff.value, last: 1'b1};
               end else if (!full) begin
                  key_we   = 1'b1;
                  val_we   = 1'b1;
                  tail_in  = slot_after(tail_ff);
                  count_in = count_ff + 1'b1;
                  rsp_in   = '{success: 1'b1, out_key: req_ff.key,
                               out_value: req_ff.value, last: 1'b1};
               end
            end
            FUNC_DEQ: begin
               if (!empty) begin
                  head_in  = slot_after(head_ff);
                  count_in = count_ff - 1'b1;
                  rsp_in   = '{success: 1'b1, out_key: $signed(key_rd),
                               out_value: $signed(val_rd), last: 1'b1};
               end
            end
            FUNC_RNG: begin
               if (hold_vld_ff) begin
                  hold_vld_in = 1'b0;
                  rsp_in      = '{success: 1'b1, out_key: $signed(hold_key_ff),
                                  out_value: $signed(hold_val_ff), last: 1'b1};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         left_ff     <= '0;
         cmp_vld_ff  <= 1'b0;
         hit_ff      <= 1'b0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         left_ff     <= left_in;
         cmp_vld_ff  <= cmp_vld_in;
         hit_ff      <= hit_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_slot_ff <= scan_slot_in;
      cmp_slot_ff  <= cmp_slot_in;
      hit_slot_ff  <= hit_slot_in;
      hold_key_ff  <= hold_key_in;
      hold_val_ff  <= hold_val_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result word overwritten before it was taken");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above queue depth");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && req_ff.func == FUNC_DEQ && !empty
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not drop the count by one");

   a_update_keeps_count: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && req_ff.func == FUNC_ENQ && hit_ff
      |=> count_ff == $past(count_ff) && tail_ff == $past(tail_ff))
      else $error("in-place update moved the tail or count");

   a_hold_only_range: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> req_ff.func == FUNC_RNG)
      else $error("held match outside a range query");
`endif

endmodule

### hdl/keyed_fifo_with_update_and_range.sv
// Keyed FIFO of up to DEPTH unique key/value pairs with in-place update, pop and
// signed range query. One word is worked on at a time. Dequeue, any unused code and
// operations on an empty queue skip the scan and go to the result. Enqueue and range
// query scan the stored keys through the single read port of the key/value rams,
// one slot per cycle (an enqueue that finds its key stops early); a range query
// also waits whenever the result channel holds back a match. A range query returns
// one word per matching entry, head to tail, with last on the final one, or a
// single failed word when nothing matches. The rams need no clearing after reset.
// A result register decouples the result channel, so the next word is accepted
// while a result is still waiting.
`timescale 1ns / 1ps

module keyed_fifo_with_update_and_range import kfu_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   kfu_cmd_type cmd;
   kfu_sts_type sts;

   kfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_data.func),
      .sts       (sts),
      .cmd       (cmd)
   );

   kfu_dp #(.DEPTH(DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
